// File: sv/alp_pkg.sv
// Package for the assembler literal parser: status and radix codes, character
// constants, and the digit and escape decoders.
// No dependencies; imported by assembler_literal_parser_top and the bench files.
package alp_pkg;

    // Width of the reported value field and of the status field.
    localparam int VALUE_BITS  = 16;
    localparam int STATUS_BITS = 3;
    localparam int CHAR_BITS   = 8;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NODIG   = 3'd2,
        ST_BADDIG  = 3'd3,
        ST_OVF     = 3'd4,
        ST_BADESC  = 3'd5,
        ST_BADCHAR = 3'd6,
        ST_LABEL   = 3'd7
    } status_t;

    // Number bases.
    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_BIN = 2'd1,
        RX_OCT = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    // Characters that steer the parser.
    localparam logic [CHAR_BITS-1:0] CH_COLON  = 8'h3A; // ':'
    localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h27; // single quote
    localparam logic [CHAR_BITS-1:0] CH_DQUOTE = 8'h22; // double quote
    localparam logic [CHAR_BITS-1:0] CH_QMARK  = 8'h3F; // '?'
    localparam logic [CHAR_BITS-1:0] CH_BSLASH = 8'h5C; // backslash
    localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30; // '0'
    localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39; // '9'
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D; // '-'
    localparam logic [CHAR_BITS-1:0] CH_LC_A   = 8'h61; // 'a'
    localparam logic [CHAR_BITS-1:0] CH_LC_B   = 8'h62; // 'b'
    localparam logic [CHAR_BITS-1:0] CH_LC_F   = 8'h66; // 'f'
    localparam logic [CHAR_BITS-1:0] CH_LC_N   = 8'h6E; // 'n'
    localparam logic [CHAR_BITS-1:0] CH_LC_O   = 8'h6F; // 'o'
    localparam logic [CHAR_BITS-1:0] CH_LC_R   = 8'h72; // 'r'
    localparam logic [CHAR_BITS-1:0] CH_LC_T   = 8'h74; // 't'
    localparam logic [CHAR_BITS-1:0] CH_LC_V   = 8'h76; // 'v'
    localparam logic [CHAR_BITS-1:0] CH_LC_X   = 8'h78; // 'x'
    localparam logic [CHAR_BITS-1:0] CH_LC_Z   = 8'h7A; // 'z'
    localparam logic [CHAR_BITS-1:0] CH_UC_A   = 8'h41; // 'A'
    localparam logic [CHAR_BITS-1:0] CH_UC_Z   = 8'h5A; // 'Z'

    // Digit value returned for a character that is no digit at all.
    localparam logic [5:0] DIGIT_NONE = 6'd36;

    // Result of decoding an escape letter.
    typedef struct packed {
        logic                 ok;
        logic [CHAR_BITS-1:0] code;
    } esc_t;

    // Digit value of a character: 0-9, then letters of either case as 10-35.
    function automatic logic [5:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [5:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 6'(c - CH_ZERO);
        end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
            d = 6'(c - CH_LC_A) + 6'd10;
        end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
            d = 6'(c - CH_UC_A) + 6'd10;
        end
        return d;
    endfunction

    // Base of a radix code.
    function automatic logic [4:0] base_of(input radix_t r);
        logic [4:0] b;
        case (r)
            RX_BIN:  b = 5'd2;
            RX_OCT:  b = 5'd8;
            RX_HEX:  b = 5'd16;
            default: b = 5'd10;
        endcase
        return b;
    endfunction

    // C escape letters; ok is low for a letter that is not known.
    function automatic esc_t escape_of(input logic [CHAR_BITS-1:0] c);
        esc_t e;
        e.ok = 1'b1;
        case (c)
            CH_QUOTE:  e.code = 8'd39;
            CH_DQUOTE: e.code = 8'd34;
            CH_QMARK:  e.code = 8'd63;
            CH_BSLASH: e.code = 8'd92;
            CH_LC_A:   e.code = 8'd7;
            CH_LC_B:   e.code = 8'd8;
            CH_LC_F:   e.code = 8'd12;
            CH_LC_N:   e.code = 8'd10;
            CH_LC_R:   e.code = 8'd13;
            CH_LC_T:   e.code = 8'd9;
            CH_LC_V:   e.code = 8'd11;
            default: begin
                e.ok   = 1'b0;
                e.code = '0;
            end
        endcase
        return e;
    endfunction

endpackage

// File: sv/assembler_literal_parser_top.sv
// Top level of the assembler literal parser: parse state, digit accumulator
// and a registered result word toward the output stream.
// Depends on alp_pkg.

// The parser takes one character word per clock unless stalled and keeps up
// with a new word in every cycle, including the cycle right after a token
// ends. The result word for a token appears on the output in the cycle after
// its final character (or its empty-token word) is accepted, and it is held
// in a single output register until taken; the input is stalled only while
// that register is full and the output is not ready. Each accepted character
// advances the token state by one step: a multiply of the accumulator by the
// small base, an add of the digit and a check of the bits above the word for
// overflow. WORD_BITS sets the width of the accumulator; the reported value
// is its low 16 bits, zero-extended when the word is narrower.
module assembler_literal_parser_top
    import alp_pkg::*;
#(
    parameter int WORD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] ch
    input  logic        s_axis_tlast,  // last character of the token
    input  logic        s_axis_tuser,  // [0] empty_token
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // [15:0] value, [18:16] status, [23:19] zero
);

    localparam int PROD_BITS = WORD_BITS + 5;

    typedef enum logic [3:0] {
        PH_START,
        PH_ZERO,
        PH_NODIG,
        PH_DIGITS,
        PH_QUOTE,
        PH_ESC,
        PH_CLOSE,
        PH_DONE,
        PH_ERR
    } phase_t;

    // Token state.
    phase_t                 phase_reg, phase_next;
    logic [WORD_BITS-1:0]   accum_reg, accum_next;
    radix_t                 radix_reg, radix_next;
    logic                   neg_reg, neg_next;
    logic [CHAR_BITS-1:0]   char_reg, char_next;
    status_t                err_reg, err_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]  out_value_reg, out_value_next;
    status_t                out_status_reg, out_status_next;

    // Digit step.
    logic                   accept;
    logic [CHAR_BITS-1:0]   ch;
    radix_t                 digit_radix;
    logic [4:0]             base;
    logic [5:0]             digit;
    logic [PROD_BITS-1:0]   prod;
    logic                   digit_bad;
    logic                   digit_ovf;
    esc_t                   esc;
    logic [WORD_BITS-1:0]   word;
    status_t                res_status;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign ch            = s_axis_tdata;

    // A number that starts here or right after a lone zero is decimal.
    assign digit_radix = (phase_reg == PH_START || phase_reg == PH_ZERO) ? RX_DEC : radix_reg;
    assign base        = base_of(digit_radix);
    assign digit       = digit_of(ch);
    assign digit_bad   = ({1'b0, base} <= digit);
    assign prod        = PROD_BITS'(accum_reg) * PROD_BITS'(base) + PROD_BITS'(digit);
    assign digit_ovf   = |prod[PROD_BITS-1:WORD_BITS];
    assign esc         = escape_of(ch);

    // Next token state for one character.
    always_comb begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        char_next  = char_reg;
        err_next   = err_reg;
        case (phase_reg)
            PH_START, PH_ZERO, PH_NODIG, PH_DIGITS: begin
                if (phase_reg == PH_START && ch == CH_COLON) begin
                    err_next   = ST_LABEL;
                    phase_next = PH_ERR;
                end else if (phase_reg == PH_START && ch == CH_QUOTE) begin
                    phase_next = PH_QUOTE;
                end else if (phase_reg == PH_START && ch == CH_ZERO) begin
                    phase_next = PH_ZERO;
                end else if (phase_reg == PH_START && ch == CH_MINUS) begin
                    neg_next   = 1'b1;
                    radix_next = RX_DEC;
                    phase_next = PH_NODIG;
                end else if (phase_reg == PH_ZERO && ch == CH_LC_B) begin
                    radix_next = RX_BIN;
                    phase_next = PH_NODIG;
                end else if (phase_reg == PH_ZERO && ch == CH_LC_O) begin
                    radix_next = RX_OCT;
                    phase_next = PH_NODIG;
                end else if (phase_reg == PH_ZERO && ch == CH_LC_X) begin
                    radix_next = RX_HEX;
                    phase_next = PH_NODIG;
                end else begin
                    // Ordinary digit in the current base.
                    radix_next = digit_radix;
                    if (digit_bad) begin
                        err_next   = ST_BADDIG;
                        phase_next = PH_ERR;
                    end else if (digit_ovf) begin
                        err_next   = ST_OVF;
                        phase_next = PH_ERR;
                    end else begin
                        accum_next = prod[WORD_BITS-1:0];
                        phase_next = PH_DIGITS;
                    end
                end
            end
            PH_QUOTE: begin
                if (ch == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end else begin
                    char_next  = ch;
                    phase_next = PH_CLOSE;
                end
            end
            PH_ESC: begin
                if (esc.ok) begin
                    char_next  = esc.code;
                    phase_next = PH_CLOSE;
                end else begin
                    err_next   = ST_BADESC;
                    phase_next = PH_ERR;
                end
            end
            PH_CLOSE: begin
                if (ch == CH_QUOTE) begin
                    phase_next = PH_DONE;
                end else begin
                    err_next   = ST_BADCHAR;
                    phase_next = PH_ERR;
                end
            end
            default: begin
                // A finished literal or a latched error ignores the rest.
            end
        endcase
    end

    // Result of the token as it stands after this character.
    always_comb begin
        word       = '0;
        res_status = ST_OK;
        case (phase_next)
            PH_ZERO:   word = '0;
            PH_DIGITS: word = neg_next ? (~accum_next + WORD_BITS'(1)) : accum_next;
            PH_DONE:   word = WORD_BITS'(char_next);
            PH_ERR:    res_status = err_next;
            PH_NODIG:  res_status = ST_NODIG;
            default:   res_status = ST_BADCHAR;
        endcase
        if (res_status != ST_OK) begin
            word = '0;
        end
    end

    // Output register next values.
    always_comb begin
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (accept && s_axis_tuser) begin
            out_valid_next  = 1'b1;
            out_value_next  = '0;
            out_status_next = ST_EMPTY;
        end else if (accept && s_axis_tlast) begin
            out_valid_next  = 1'b1;
            out_value_next  = VALUE_BITS'(word);
            out_status_next = res_status;
        end
    end

    // State and output registers; a token end returns the state to its start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            accum_reg     <= '0;
            radix_reg     <= RX_DEC;
            neg_reg       <= 1'b0;
            char_reg      <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                if (s_axis_tuser || s_axis_tlast) begin
                    phase_reg <= PH_START;
                    accum_reg <= '0;
                    radix_reg <= RX_DEC;
                    neg_reg   <= 1'b0;
                    char_reg  <= '0;
                    err_reg   <= ST_OK;
                end else begin
                    phase_reg <= phase_next;
                    accum_reg <= accum_next;
                    radix_reg <= radix_next;
                    neg_reg   <= neg_next;
                    char_reg  <= char_next;
                    err_reg   <= err_next;
                end
            end
        end
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_status_reg, out_value_reg};

`ifndef SYNTHESIS
    // An error result always carries a zero value.
    a_err_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_status_reg != ST_OK) |-> (out_value_reg == '0))
        else $error("error result with nonzero value");

    // A token end puts a result word on the output in the next cycle.
    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_axis_tlast || s_axis_tuser)) |=> m_axis_tvalid)
        else $error("token end without result");

    // A token end returns the parser to the start of a token.
    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_axis_tlast || s_axis_tuser)) |=>
        (phase_reg == PH_START && accum_reg == '0 && !neg_reg))
        else $error("state not cleared after token end");

    // The input stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (out_valid_reg && !m_axis_tready))
        else $error("input stalled without a waiting result");
`endif

endmodule

// File: bench/alp_parse_checker.sv
// Scoreboard for the assembler literal parser: follows every accepted character
// word, predicts the token results and compares them with the output stream.
// Depends on alp_pkg for the status and radix codes and the character constants.
module alp_parse_checker
    import alp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    output int          failures,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_MAX = 65535;

    // Token parse phases of the predictor.
    typedef enum logic [3:0] {
        P_START, P_ZERO, P_NODIG, P_DIGITS, P_QUOTE, P_ESC, P_CLOSE, P_DONE, P_ERR
    } parse_phase_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        status_t               status;
    } parse_result_t;

    parse_result_t expected_results[$];

    // Predicted token state.
    parse_phase_t   ph;
    logic [15:0]    acc;
    radix_t         rdx;
    logic           neg;
    logic [7:0]     chv;
    status_t        err;

    int failure_count = 0;
    int queued = 0;

    assign failures = failure_count;
    assign pending  = queued;

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        failure_count++;
    endtask

    task automatic clear_token();
        ph  = P_START;
        acc = '0;
        rdx = RX_DEC;
        neg = 1'b0;
        chv = '0;
        err = ST_OK;
    endtask

    // The first error of a token sticks; later characters are ignored.
    task automatic latch_error(input status_t code);
        err = code;
        ph  = P_ERR;
    endtask

    function automatic int digit_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c) - int'(CH_ZERO);
        end
        if (c >= CH_LC_A && c <= CH_LC_Z) begin
            return int'(c) - int'(CH_LC_A) + 10;
        end
        if (c >= CH_UC_A && c <= CH_UC_Z) begin
            return int'(c) - int'(CH_UC_A) + 10;
        end
        return 36;
    endfunction

    function automatic int base_value(input radix_t r);
        case (r)
            RX_BIN:  return 2;
            RX_OCT:  return 8;
            RX_HEX:  return 16;
            default: return 10;
        endcase
    endfunction

    // Value of a C escape letter, or -1 when the letter is unknown.
    function automatic int escape_code(input logic [7:0] c);
        case (c)
            CH_QUOTE:  return 39;
            CH_DQUOTE: return 34;
            CH_QMARK:  return 63;
            CH_BSLASH: return 92;
            CH_LC_A:   return 7;
            CH_LC_B:   return 8;
            CH_LC_F:   return 12;
            CH_LC_N:   return 10;
            CH_LC_R:   return 13;
            CH_LC_T:   return 9;
            CH_LC_V:   return 11;
            default:   return -1;
        endcase
    endfunction

    // Shift in one digit; the word must not pass its maximum.
    task automatic take_digit(input logic [7:0] c);
        int base;
        int d;
        int next;
        base = base_value(rdx);
        d    = digit_value(c);
        next = int'(acc) * base + d;
        if (d >= base) begin
            latch_error(ST_BADDIG);
        end else if (next > WORD_MAX) begin
            latch_error(ST_OVF);
        end else begin
            acc = 16'(next);
            ph  = P_DIGITS;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        int e;
        case (ph)
            P_START: begin
                if (c == CH_COLON) begin
                    latch_error(ST_LABEL);
                end else if (c == CH_QUOTE) begin
                    ph = P_QUOTE;
                end else if (c == CH_ZERO) begin
                    ph = P_ZERO;
                end else if (c == CH_MINUS) begin
                    neg = 1'b1;
                    rdx = RX_DEC;
                    ph  = P_NODIG;
                end else begin
                    rdx = RX_DEC;
                    take_digit(c);
                end
            end
            // Only lowercase letters after a leading zero select a prefix.
            P_ZERO: begin
                if (c == CH_LC_B) begin
                    rdx = RX_BIN;
                    ph  = P_NODIG;
                end else if (c == CH_LC_O) begin
                    rdx = RX_OCT;
                    ph  = P_NODIG;
                end else if (c == CH_LC_X) begin
                    rdx = RX_HEX;
                    ph  = P_NODIG;
                end else begin
                    rdx = RX_DEC;
                    acc = '0;
                    ph  = P_DIGITS;
                    take_digit(c);
                end
            end
            P_NODIG, P_DIGITS: begin
                take_digit(c);
            end
            P_QUOTE: begin
                if (c == CH_BSLASH) begin
                    ph = P_ESC;
                end else begin
                    chv = c;
                    ph  = P_CLOSE;
                end
            end
            P_ESC: begin
                e = escape_code(c);
                if (e < 0) begin
                    latch_error(ST_BADESC);
                end else begin
                    chv = 8'(e);
                    ph  = P_CLOSE;
                end
            end
            P_CLOSE: begin
                if (c == CH_QUOTE) begin
                    ph = P_DONE;
                end else begin
                    latch_error(ST_BADCHAR);
                end
            end
            default: begin
            end
        endcase
    endtask

    // Advance the prediction by one accepted word and queue a result at token end.
    task automatic predict_word(input logic [7:0] c, input logic l, input logic e);
        parse_result_t r;
        r.value  = '0;
        r.status = ST_OK;
        if (e) begin
            r.status = ST_EMPTY;
            expected_results = {expected_results, r};
            clear_token();
        end else begin
            parse_char(c);
            if (l) begin
                case (ph)
                    P_ZERO:   r.value = '0;
                    P_DIGITS: r.value = neg ? 16'(~acc + 16'd1) : acc;
                    P_DONE:   r.value = {8'h00, chv};
                    P_ERR:    r.status = err;
                    P_NODIG:  r.status = ST_NODIG;
                    default:  r.status = ST_BADCHAR;
                endcase
                if (r.status != ST_OK) begin
                    r.value = '0;
                end
                expected_results = {expected_results, r};
                clear_token();
            end
        end
    endtask

    task automatic check_result(input logic [23:0] data);
        parse_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result word with no token pending", data, '0);
        end else begin
            want = expected_results.pop_front();
            if (data[15:0] !== want.value) begin
                report_mismatch("value", data[15:0], want.value);
            end
            if (data[18:16] !== want.status) begin
                report_mismatch("status", data[18:16], want.status);
            end
            if (data[23:19] !== 5'd0) begin
                report_mismatch("padding bits", data[23:19], '0);
            end
        end
    endtask

    // Inputs are handled before outputs, so a prediction is always queued in time.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_token();
            expected_results.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_word(s_axis_tdata, s_axis_tlast, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
            end
        end
        queued = expected_results.size();
    end

endmodule

// File: bench/assembler_literal_parser_top_tb.sv
// Testbench top for the assembler literal parser: clock, reset, token stimulus
// with random sender gaps and receiver stalls, and the final verdict.
// Depends on alp_pkg, assembler_literal_parser_top and alp_parse_checker.
module assembler_literal_parser_top_tb
    import alp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1850;
    localparam int LIMIT_CYCLES = 200000;

    localparam logic [7:0] ESC_LETTERS [11] = '{
        CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH, CH_LC_A, CH_LC_B,
        CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T, CH_LC_V
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    int failures;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int abort_pct = 0;
    int words_sent = 0;
    int cycle_count = 0;

    logic [7:0] token_chars[$];

    string directed_texts[] = '{
        "0", "0x", "0b", "0o", "-", "0xFFFF", "0xffff", "0x10000", "65535", "65536",
        "-1", "-32768", "0b1111111111111111", "0o177777", "0o200000", "0B1", "12a",
        "7+", ":lab", "'a'", "'\\n'", "'\\q'", "'ab", "'", "'\\", "'z'junk", "0zZ"
    };

    string short_forms[] = '{
        "0x", "0b", "0o", "-", "'", "'\\", "'a", "'\\n", "0", "0B1", "0X1", "0123"
    };

    assembler_literal_parser_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    alp_parse_checker parse_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .failures      (failures),
        .pending       (pending)
    );

    // Clock generator.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog on the cycle count.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offer one word, with random gaps before it, and wait until it is taken.
    // Ready is sampled at the falling edge, where it is settled.
    task automatic send_word(input logic [7:0] c, input logic l, input logic e);
        logic taken;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= l;
        s_axis_tuser  <= e;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_axis_tready;
            @(posedge aclk);
        end
        words_sent++;
    endtask

    // Append one character to the token under construction.
    task automatic add_char(input logic [7:0] c);
        token_chars = {token_chars, c};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i]);
        end
    endtask

    // Random digits below the base, letters in either case.
    task automatic push_digits(input int base, input int n);
        int v;
        repeat (n) begin
            v = $urandom_range(0, base - 1);
            if (v < 10) begin
                add_char(8'(int'(CH_ZERO) + v));
            end else if ($urandom_range(0, 1) != 0) begin
                add_char(8'(int'(CH_UC_A) + v - 10));
            end else begin
                add_char(8'(int'(CH_LC_A) + v - 10));
            end
        end
    endtask

    task automatic push_noise(input int n);
        repeat (n) begin
            add_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Send the queued token; an empty queue becomes an empty-token word.
    // Now and then an empty-token word cuts into the token.
    task automatic send_token();
        int n;
        n = token_chars.size();
        if (n == 0) begin
            send_word(8'($urandom), 1'($urandom), 1'b1);
        end else begin
            for (int i = 0; i < n; i++) begin
                if (i > 0 && $urandom_range(0, 99) < abort_pct) begin
                    send_word(8'($urandom), 1'($urandom), 1'b1);
                end
                send_word(token_chars[i], (i == n - 1), 1'b0);
            end
        end
    endtask

    // Mostly well-formed literals with random content, the rest broken or noise.
    task automatic build_random_token();
        int kind;
        int pick;
        token_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            push_text("0x");
            push_digits(16, $urandom_range(1, 5));
        end else if (kind < 20) begin
            push_text("0b");
            push_digits(2, $urandom_range(1, 18));
        end else if (kind < 28) begin
            push_text("0o");
            push_digits(8, $urandom_range(1, 7));
        end else if (kind < 44) begin
            push_digits(10, $urandom_range(1, 6));
        end else if (kind < 54) begin
            push_text("-");
            push_digits(10, $urandom_range(1, 6));
        end else if (kind < 62) begin
            add_char(CH_QUOTE);
            push_noise(1);
            add_char(CH_QUOTE);
        end else if (kind < 70) begin
            add_char(CH_QUOTE);
            add_char(CH_BSLASH);
            pick = $urandom_range(0, 12);
            if (pick < 11) begin
                add_char(ESC_LETTERS[pick]);
            end else begin
                push_noise(1);
            end
            add_char(CH_QUOTE);
        end else if (kind < 73) begin
            add_char(CH_COLON);
            push_noise($urandom_range(0, 3));
        end else if (kind < 80) begin
            // A number with one character replaced by an arbitrary byte.
            if ($urandom_range(0, 1) != 0) begin
                push_text("0x");
                push_digits(16, $urandom_range(1, 4));
            end else begin
                push_digits(10, $urandom_range(1, 5));
            end
            token_chars[$urandom_range(0, token_chars.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind < 85) begin
            push_text(short_forms[$urandom_range(0, short_forms.size() - 1)]);
        end else if (kind < 89) begin
            add_char(CH_QUOTE);
            push_noise(1);
            add_char(CH_QUOTE);
            push_noise($urandom_range(1, 3));
        end else if (kind < 93) begin
            // Leave the token empty.
        end else begin
            push_noise($urandom_range(1, 5));
        end
    endtask

    // Main stimulus.
    initial begin
        int target;
        int idle_by_phase[4];
        int stall_by_phase[4];
        idle_by_phase  = '{0, 69, 0, 31};
        stall_by_phase = '{0, 0, 69, 31};

        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed tokens, no idling.
        foreach (directed_texts[i]) begin
            token_chars.delete();
            push_text(directed_texts[i]);
            send_token();
        end
        send_word(8'hA5, 1'b1, 1'b1);
        token_chars = '{CH_QUOTE, 8'hFF, CH_QUOTE};
        send_token();
        token_chars = '{8'h00};
        send_token();
        // A partly received token abandoned by an empty-token word.
        send_word(CH_ZERO, 1'b0, 1'b0);
        send_word(CH_LC_X, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
        send_word(CH_NINE, 1'b1, 1'b0);

        // Random tokens over the idling phases.
        abort_pct = 2;
        target = words_sent;
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            target += RANDOM_WORDS / 4;
            while (words_sent < target) begin
                build_random_token();
                send_token();
            end
        end

        // Drain the outstanding results.
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
sv/alp_pkg.sv
sv/assembler_literal_parser_top.sv
bench/alp_parse_checker.sv
bench/assembler_literal_parser_top_tb.sv
